FILE: src/msfr_pkg.sv
// Shared types and constants for the motor status frame receiver.
package msfr_pkg;

  localparam logic [3:0] FRAME_LAST  = 4'd10;
  localparam logic [3:0] POS_DEVICE  = 4'd1;
  localparam logic [3:0] POS_COMMAND = 4'd2;
  localparam logic [3:0] POS_STATUS  = 4'd4;
  localparam logic [3:0] POS_LOW     = 4'd5;
  localparam logic [3:0] POS_HIGH    = 4'd6;
  localparam logic [3:0] POS_FIRST   = 4'd0;

  localparam logic [7:0] CMD_DONE = 8'h0f;
  localparam logic [7:0] CMD_ACK  = 8'h0c;

  localparam logic [7:0] AXIS_X    = 8'h00;
  localparam logic [7:0] AXIS_Y    = 8'h01;
  localparam logic [7:0] AXIS_LAST = 8'h02;

  typedef enum logic [1:0] {
    KIND_DONE     = 2'd0,
    KIND_ACK      = 2'd1,
    KIND_OTHER    = 2'd2,
    KIND_CSUM_ERR = 2'd3
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [7:0]  device;
    logic [15:0] position;
    logic [6:0]  stop;
    logic        x_done;
    logic        y_done;
  } msfr_result_t;

endpackage

FILE: src/motor_status_frame_receiver.sv
// Top level of the motor status frame receiver.
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   in_rx_byte, in_frame_start
//  out_     output     out_valid / out_stall out_frame_kind, out_unit_id,
//                                            out_axis_position, out_stop_flags,
//                                            out_x_axis_done, out_y_axis_done
//
// One byte is taken per cycle while in_stall is low; state updates on accept.
// The result of a frame is registered on out_ from its checksum byte.
// Reset (rst_n low, synchronous) clears the count, sum, held bytes and flags.
// A stalled result waits in the output register; one more result fits in a
// skid entry, and in_stall rises only while that entry is occupied.
module motor_status_frame_receiver
  import msfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_kind,
  output logic [7:0]  out_unit_id,
  output logic [15:0] out_axis_position,
  output logic [6:0]  out_stop_flags,
  output logic        out_x_axis_done,
  output logic        out_y_axis_done
);

  logic         accept;
  logic         res_valid;
  logic         buf_full;
  msfr_result_t res;
  msfr_result_t out_res;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  msfr_frame_asm u_frame_asm (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  msfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_frame_kind    = out_res.kind;
  assign out_unit_id       = out_res.device;
  assign out_axis_position = out_res.position;
  assign out_stop_flags    = out_res.stop;
  assign out_x_axis_done   = out_res.x_done;
  assign out_y_axis_done   = out_res.y_done;

endmodule

FILE: src/msfr_frame_asm.sv
// Frame assembly: byte count, running sum, held bytes, flags and frame classification.
module msfr_frame_asm
  import msfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   rx_byte,
  input  logic         frame_start,
  output logic         res_valid,
  output msfr_result_t res
);

  logic [3:0] byte_count_r, byte_count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] device_r, device_nxt;
  logic [7:0] command_r, command_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] pos_low_r, pos_low_nxt;
  logic [7:0] pos_high_r, pos_high_nxt;
  logic [6:0] flags_r, flags_nxt;
  logic       x_done_r, x_done_nxt;
  logic       y_done_r, y_done_nxt;

  logic [3:0]  idx;
  logic        last;
  logic        sum_ok;
  logic        good_done;
  logic        axis_hit;
  frame_kind_t kind;

  // frame_start restarts the count; anything at or past the last slot is the checksum byte
  assign idx       = frame_start ? POS_FIRST : byte_count_r;
  assign last      = (idx >= FRAME_LAST);
  assign sum_ok    = (sum_r == rx_byte);
  assign good_done = sum_ok && (command_r == CMD_DONE);
  assign axis_hit  = good_done && (device_r <= AXIS_LAST);

  always_comb begin
    if (!sum_ok) begin
      kind = KIND_CSUM_ERR;
    end else if (command_r == CMD_DONE) begin
      kind = KIND_DONE;
    end else if (command_r == CMD_ACK) begin
      kind = KIND_ACK;
    end else begin
      kind = KIND_OTHER;
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    sum_nxt        = sum_r;
    device_nxt     = device_r;
    command_nxt    = command_r;
    status_nxt     = status_r;
    pos_low_nxt    = pos_low_r;
    pos_high_nxt   = pos_high_r;
    flags_nxt      = flags_r;
    x_done_nxt     = x_done_r;
    y_done_nxt     = y_done_r;
    if (accept) begin
      if (!last) begin
        sum_nxt        = (idx == POS_FIRST) ? rx_byte : 8'(sum_r + rx_byte);
        byte_count_nxt = 4'(idx + 4'd1);
        case (idx)
          POS_DEVICE:  device_nxt   = rx_byte;
          POS_COMMAND: command_nxt  = rx_byte;
          POS_STATUS:  status_nxt   = rx_byte;
          POS_LOW:     pos_low_nxt  = rx_byte;
          POS_HIGH:    pos_high_nxt = rx_byte;
          default:     ;
        endcase
      end else begin
        byte_count_nxt = POS_FIRST;
        if (good_done) begin
          flags_nxt = status_r[6:0];
        end
        if (axis_hit && (device_r == AXIS_X)) begin
          x_done_nxt = 1'b1;
        end
        if (axis_hit && (device_r == AXIS_Y)) begin
          y_done_nxt = 1'b1;
        end
      end
    end
  end

  assign res_valid    = accept && last;
  assign res.kind     = kind;
  assign res.device   = device_r;
  assign res.position = axis_hit ? {pos_high_r, pos_low_r} : 16'h0000;
  assign res.stop     = flags_nxt;
  assign res.x_done   = x_done_nxt;
  assign res.y_done   = y_done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      sum_r        <= '0;
      device_r     <= '0;
      command_r    <= '0;
      status_r     <= '0;
      pos_low_r    <= '0;
      pos_high_r   <= '0;
      flags_r      <= '0;
      x_done_r     <= 1'b0;
      y_done_r     <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      sum_r        <= sum_nxt;
      device_r     <= device_nxt;
      command_r    <= command_nxt;
      status_r     <= status_nxt;
      pos_low_r    <= pos_low_nxt;
      pos_high_r   <= pos_high_nxt;
      flags_r      <= flags_nxt;
      x_done_r     <= x_done_nxt;
      y_done_r     <= y_done_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= FRAME_LAST)
    else $error("byte count past the checksum slot");

  a_wrap_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (byte_count_r == POS_FIRST))
    else $error("count did not wrap after a frame result");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (x_done_r || y_done_r) |=>
      ((x_done_r || !$past(x_done_r)) && (y_done_r || !$past(y_done_r))))
    else $error("sticky done flag cleared");

  a_flags_only_on_good_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && good_done) |=> $stable(flags_r))
    else $error("status flags changed outside a good completion frame");

endmodule

FILE: src/msfr_out_buf.sv
// Result register with one skid entry, so a result waiting in the output register does not block new bytes.
module msfr_out_buf
  import msfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_valid,
  input  msfr_result_t res,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output msfr_result_t out_res
);

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  msfr_result_t out_r, out_nxt;
  msfr_result_t skid_r, skid_nxt;
  logic         out_free;

  // output slot can take a new request this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // advance the held request once the output drains
      if (out_free) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall && res_valid))
    else $error("skid filled without a stalled output");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && skid_valid_r) |-> 1'b0)
    else $error("result produced while skid entry occupied");

endmodule
